### hdl/u8v_pkg.sv
// shared types and constants for the utf-8 sequence validator
`timescale 1ns / 1ps

package u8v_pkg;

  localparam int unsigned MAX_SEQUENCE_BYTES = 4;
  localparam int unsigned MAX_RESULTS        = 4;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_LEAD  = 3'd1;
  localparam status_t ST_BAD_CONT  = 3'd2;
  localparam status_t ST_TRUNCATED = 3'd3;
  localparam status_t ST_RANGE     = 3'd4;
  localparam status_t ST_SURROGATE = 3'd5;

  localparam logic [7:0]  REPL_BYTE0 = 8'hEF;
  localparam logic [7:0]  REPL_BYTE1 = 8'hBF;
  localparam logic [7:0]  REPL_BYTE2 = 8'hBD;
  localparam logic [20:0] REPL_CP    = 21'h00FFFD;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [20:0] code_point;
    status_t     status;
    logic        is_last;
  } result_t;

  // open sequence bookkeeping
  typedef struct packed {
    logic [2:0] exp_len;
    logic [2:0] rcv_cnt;
  } seq_state_t;

  // write into the sequence byte store
  typedef struct packed {
    logic       en;
    logic [1:0] idx;
    logic [7:0] data;
  } byte_wr_t;

endpackage

### hdl/u8v_decode.sv
// combinational step logic: classifies one byte and builds its result items
`timescale 1ns / 1ps

module u8v_decode (
  input  logic                 strict_mode,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_input,
  input  u8v_pkg::seq_state_t  state,
  input  logic [7:0]           seq_byte0,
  input  logic [7:0]           seq_byte1,
  input  logic [7:0]           seq_byte2,
  output u8v_pkg::seq_state_t  state_nxt,
  output u8v_pkg::byte_wr_t    byte_wr,
  output u8v_pkg::result_t     results [u8v_pkg::MAX_RESULTS],
  output logic [2:0]           num_results
);

  logic               seq_open;
  logic               is_cont;
  logic [2:0]         lead_len;
  logic [2:0]         rcv_inc;
  logic [20:0]        cp;
  logic               overlong;
  logic               surrogate;
  logic               err_en;
  u8v_pkg::status_t   err_st;
  logic               ascii_en;
  logic               echo_en;
  u8v_pkg::status_t   fin_st;
  u8v_pkg::result_t   ascii_res;

  assign seq_open = (state.exp_len != 3'd0);
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign rcv_inc  = state.rcv_cnt + 3'd1;

  always_comb begin
    if (data_byte[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  // code point of the sequence closed by this byte
  always_comb begin
    case (state.exp_len)
      3'd2:    cp = {10'd0, seq_byte0[4:0], data_byte[5:0]};
      3'd3:    cp = {5'd0, seq_byte0[3:0], seq_byte1[5:0], data_byte[5:0]};
      default: cp = {seq_byte0[2:0], seq_byte1[5:0], seq_byte2[5:0], data_byte[5:0]};
    endcase
  end

  always_comb begin
    case (state.exp_len)
      3'd2:    overlong = (cp < 21'h80);
      3'd3:    overlong = (cp < 21'h800);
      default: overlong = (cp < 21'h10000) || (cp > 21'h10FFFF);
    endcase
  end

  assign surrogate = (cp >= 21'h00D800) && (cp <= 21'h00DFFF);

  always_comb begin
    if (surrogate) begin
      fin_st = u8v_pkg::ST_SURROGATE;
    end else if (overlong) begin
      fin_st = u8v_pkg::ST_RANGE;
    end else begin
      fin_st = u8v_pkg::ST_OK;
    end
  end

  // decide what happens to this byte
  always_comb begin
    state_nxt = state;
    byte_wr   = '0;
    err_en    = 1'b0;
    err_st    = u8v_pkg::ST_OK;
    ascii_en  = 1'b0;
    echo_en   = 1'b0;
    if (end_of_input) begin
      if (seq_open) begin
        err_en    = 1'b1;
        err_st    = u8v_pkg::ST_TRUNCATED;
        state_nxt = '0;
      end
    end else if (seq_open && is_cont) begin
      byte_wr.en        = (state.rcv_cnt < 3'd3);
      byte_wr.idx       = state.rcv_cnt[1:0];
      byte_wr.data      = data_byte;
      state_nxt.rcv_cnt = rcv_inc;
      if (rcv_inc == state.exp_len) begin
        state_nxt = '0;
        if (fin_st == u8v_pkg::ST_OK) begin
          echo_en = 1'b1;
        end else begin
          err_en = 1'b1;
          err_st = fin_st;
        end
      end
    end else begin
      // bad continuation closes the open sequence, byte then starts afresh
      if (seq_open) begin
        err_en    = 1'b1;
        err_st    = u8v_pkg::ST_BAD_CONT;
        state_nxt = '0;
      end
      if (!data_byte[7]) begin
        ascii_en = 1'b1;
      end else if (lead_len != 3'd0) begin
        byte_wr.en        = 1'b1;
        byte_wr.idx       = 2'd0;
        byte_wr.data      = data_byte;
        state_nxt.exp_len = lead_len;
        state_nxt.rcv_cnt = 3'd1;
      end else if (!seq_open) begin
        // a bad lead that breaks an open sequence is dropped quietly
        err_en = 1'b1;
        err_st = u8v_pkg::ST_BAD_LEAD;
      end
    end
  end

  assign ascii_res = '{out_byte: data_byte, code_point: {13'd0, data_byte},
                       status: u8v_pkg::ST_OK, is_last: 1'b1};

  // place result items
  always_comb begin
    for (int i = 0; i < u8v_pkg::MAX_RESULTS; i++) begin
      results[i] = '0;
    end
    num_results = 3'd0;
    if (echo_en) begin
      results[0] = '{out_byte: seq_byte0, code_point: '0, status: u8v_pkg::ST_OK, is_last: 1'b0};
      results[1] = '{out_byte: seq_byte1, code_point: '0, status: u8v_pkg::ST_OK, is_last: 1'b0};
      results[2] = '{out_byte: seq_byte2, code_point: '0, status: u8v_pkg::ST_OK, is_last: 1'b0};
      results[state.exp_len[1:0] - 2'd1] =
        '{out_byte: data_byte, code_point: cp, status: u8v_pkg::ST_OK, is_last: 1'b1};
      num_results = state.exp_len;
    end else begin
      if (err_en) begin
        if (strict_mode) begin
          results[0] = '{out_byte: 8'd0, code_point: '0, status: err_st, is_last: 1'b1};
          num_results = 3'd1;
        end else begin
          results[0] = '{out_byte: u8v_pkg::REPL_BYTE0, code_point: '0,
                         status: err_st, is_last: 1'b0};
          results[1] = '{out_byte: u8v_pkg::REPL_BYTE1, code_point: '0,
                         status: err_st, is_last: 1'b0};
          results[2] = '{out_byte: u8v_pkg::REPL_BYTE2, code_point: u8v_pkg::REPL_CP,
                         status: err_st, is_last: 1'b1};
          num_results = 3'd3;
        end
      end
      if (ascii_en) begin
        results[num_results[1:0]] = ascii_res;
        num_results = num_results + 3'd1;
      end
    end
  end

endmodule

### hdl/utf8_sequence_validator.sv
// top level of the utf-8 sequence validator: state, config and result queue
`timescale 1ns / 1ps

// Streaming UTF-8 checker and decoder. One byte enters per item on in_tdata;
// in_tlast marks the end of the stream and carries no byte (an open sequence
// is then reported truncated). ASCII bytes come back as one result item each.
// The bytes of a multi-byte character are held until the last one arrives and
// are then echoed as 2 to 4 result items, the last of which carries the code
// point in out_tdata and has out_tlast set. Errors (status on out_tuser) give
// one item with byte 0 when strict_mode is 1, or the three bytes EF BF BD
// otherwise; a bad continuation byte also gets handled as a new lead, so one
// input item can give up to four result items. Every input item is decoded
// in the cycle it is accepted and its results show from the next cycle on in
// a four-entry result register that drains one item per cycle while
// out_tready is high. A new input item is taken as soon as that register is
// empty or its last entry is being taken, so with no output stall the block
// runs at one byte per cycle while each byte gives at most one result, and
// otherwise at the output rate of one result item per cycle. strict_mode
// resets to 1 and may be written only while no item is in flight.
module utf8_sequence_validator (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // strict_mode
  // byte stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // [7:0] data_byte
  input  logic        in_tlast,       // end_of_input
  // result stream out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,      // [7:0] out_byte, [28:8] code_point, [31:29] zero
  output logic [2:0]  out_tuser,      // [2:0] status
  output logic        out_tlast       // is_last
);

  logic                 strict_r;
  u8v_pkg::seq_state_t  state_r;
  u8v_pkg::seq_state_t  state_nxt;
  logic [7:0]           seq_bytes_r [3];   // last byte of a 4-byte sequence is never stored
  u8v_pkg::byte_wr_t    byte_wr;

  u8v_pkg::result_t     dec_res [u8v_pkg::MAX_RESULTS];
  logic [2:0]           dec_num;

  // result queue: filled all at once, drained one item per cycle unless stalled
  u8v_pkg::result_t     res_r [u8v_pkg::MAX_RESULTS];
  logic [2:0]           cnt_r;
  logic [1:0]           head_r;
  u8v_pkg::result_t     head_res;

  logic                 in_fire;
  logic                 out_fire;

  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);
  assign in_fire   = in_tvalid && in_tready;

  u8v_decode u_decode (
    .strict_mode  (strict_r),
    .data_byte    (in_tdata),
    .end_of_input (in_tlast),
    .state        (state_r),
    .seq_byte0    (seq_bytes_r[0]),
    .seq_byte1    (seq_bytes_r[1]),
    .seq_byte2    (seq_bytes_r[2]),
    .state_nxt    (state_nxt),
    .byte_wr      (byte_wr),
    .results      (dec_res),
    .num_results  (dec_num)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b1;
    end else if (cfg_wr_en) begin
      strict_r <= cfg_wr_data;
    end
  end

  // open sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // sequence byte store, no reset: every entry is written before its byte is used
  always_ff @(posedge clk) begin
    if (in_fire && byte_wr.en) begin
      seq_bytes_r[byte_wr.idx] <= byte_wr.data;
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      head_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r  <= dec_num;
      head_r <= 2'd0;
    end else if (out_fire) begin
      cnt_r  <= cnt_r - 3'd1;
      head_r <= head_r + 2'd1;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < u8v_pkg::MAX_RESULTS; i++) begin
        res_r[i] <= dec_res[i];
      end
    end
  end

  assign head_res   = res_r[head_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {3'd0, head_res.code_point, head_res.out_byte};
  assign out_tuser  = head_res.status;
  assign out_tlast  = head_res.is_last;

endmodule

### hdl/u8v_checker.sv
// port-level checks for the utf-8 sequence validator, bound to the top level
`timescale 1ns / 1ps

module u8v_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result item changed");

  // an ok ascii byte is a whole character and carries itself as code point
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[7] && out_tuser == u8v_pkg::ST_OK |->
    out_tlast && out_tdata[28:8] == {13'd0, out_tdata[7:0]})
    else $error("ascii result malformed");

  // only the last item of a character carries a code point
  a_cp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[28:8] == 21'd0)
    else $error("code point on a non-final result item");

  // final error item is either the strict report or the end of the replacement
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser != u8v_pkg::ST_OK |->
    (out_tdata[28:0] == 29'd0) ||
    (out_tdata[7:0] == u8v_pkg::REPL_BYTE2 && out_tdata[28:8] == u8v_pkg::REPL_CP))
    else $error("bad final error item");

endmodule

bind utf8_sequence_validator u8v_checker u_u8v_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
